@@ hw/rtl/pd_scp_pkg.sv @@
`default_nettype none

package pd_scp_pkg;

	localparam int MAX_ENTRIES_DEF = 10;
	// bytes at or past this position are dropped
	localparam int MAX_MSG_BYTES = 48;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_CHECK = 2'd1;
	localparam logic [1:0] OP_LIMIT = 2'd2;
	localparam logic [1:0] OP_COUNT = 2'd3;

	localparam logic [1:0] RK_ENTRY = 2'd0;
	localparam logic [1:0] RK_ERROR = 2'd1;
	localparam logic [1:0] RK_QUERY = 2'd2;

	localparam logic [2:0] KIND_EMPTY = 3'd0;
	localparam logic [2:0] KIND_FIXED = 3'd1;
	localparam logic [2:0] KIND_PPS   = 3'd2;
	localparam logic [2:0] KIND_AVS   = 3'd3;
	localparam logic [2:0] KIND_RSVD  = 3'd4;

	localparam logic [1:0] PDO_FIXED = 2'd0;
	localparam logic [1:0] PDO_APDO  = 2'd3;
	localparam logic [1:0] APDO_PPS  = 2'd0;
	localparam logic [1:0] APDO_AVS  = 2'd1;

	localparam logic [15:0] FIXED_MV_STEP = 16'd50;
	localparam logic [15:0] FIXED_MA_STEP = 16'd10;
	localparam logic [15:0] APDO_MV_STEP  = 16'd100;
	localparam logic [15:0] PPS_MA_STEP   = 16'd50;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WALK,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  msg_byte;
		logic        first_byte;
		logic [15:0] req_mv;
		logic [1:0]  limit_kind;
		logic        want_max;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [3:0]  entry_index;
		logic [2:0]  entry_kind;
		logic [15:0] value_a;
		logic [15:0] value_b;
		logic [15:0] value_c;
		logic        last_entry;
		logic        found;
		logic [15:0] limit_mv;
		logic [3:0]  fixed_count;
		logic        has_pps;
		logic        has_avs;
	} res_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] val_a;
		logic [15:0] val_b;
		logic [15:0] val_c;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic wr_en;
		logic rd_en;
	} tbl_ctl_t;

	function automatic entry_t decode_pdo(input logic [31:0] w);
		entry_t e;
		e = '0;
		e.kind = KIND_RSVD;
		if (w[31:30] == PDO_FIXED) begin
			e.kind  = KIND_FIXED;
			e.val_a = {6'd0, w[19:10]} * FIXED_MV_STEP;
			e.val_b = {6'd0, w[9:0]} * FIXED_MA_STEP;
		end else if (w[31:30] == PDO_APDO) begin
			if (w[29:28] == APDO_PPS) begin
				e.kind  = KIND_PPS;
				e.val_a = {8'd0, w[15:8]} * APDO_MV_STEP;
				e.val_b = {8'd0, w[24:17]} * APDO_MV_STEP;
				e.val_c = {9'd0, w[6:0]} * PPS_MA_STEP;
			end else if (w[29:28] == APDO_AVS) begin
				e.kind  = KIND_AVS;
				e.val_a = {8'd0, w[15:8]} * APDO_MV_STEP;
				e.val_b = {7'd0, w[25:17]} * APDO_MV_STEP;
				e.val_c = {8'd0, w[7:0]};
			end
		end
		return e;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pd_source_cap_parser.sv @@
`default_nettype none

// Source_Capabilities parser. Message bytes (opcode load) arrive least significant
// byte first; each byte is accepted in idle and handled in the load state before
// the next is taken, and every fourth object byte writes one decoded entry into
// the table and emits it. A query (check voltage, PPS/AVS limit, fixed count)
// walks the table through its single read port, one slot per cycle. The table
// comes out of reset empty with no clearing pass. One result register sits on the
// output, so a new command is taken while an earlier result waits; the block
// stalls only when a second result is ready.
module pd_source_cap_parser #(
	parameter int MAX_ENTRIES = pd_scp_pkg::MAX_ENTRIES_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cmd_valid,
	output logic                  cmd_ready,
	input  wire pd_scp_pkg::cmd_t cmd,
	output logic                  res_valid,
	input  wire                   res_ready,
	output pd_scp_pkg::res_t      res
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	pd_scp_pkg::state_t state_q, state_n;
	pd_scp_pkg::cmd_t   item_q;
	pd_scp_pkg::res_t   res_q;
	pd_scp_pkg::res_t   qry_res;
	logic               res_valid_q;
	logic               out_free;

	// message parser state
	logic [5:0]  pos_q;
	logic [15:0] hdr_q;
	logic [2:0]  cnt_q;
	logic [31:0] word_q;
	logic        err_q;

	logic [5:0]  ld_pos, ld_pos_n, ld_off, ld_rel;
	logic [15:0] ld_hdr, ld_hdr_n;
	logic [2:0]  ld_cnt, ld_cnt_n;
	logic [31:0] ld_word, ld_word_n;
	logic        ld_err, ld_err_n;
	logic [3:0]  ld_idx;
	logic        ld_res_en, ld_wr_en;
	pd_scp_pkg::res_t   ld_res;
	pd_scp_pkg::entry_t ld_entry;
	logic        ld_go, rep_go, accept;

	// table walk
	logic [CNT_W-1:0] walk_idx_q;
	logic             walk_issue;
	logic             rd_vld_s1, rd_last_s1;
	logic             found_q, lim_done_q, pps_q, avs_q;
	logic [15:0]      limit_q;
	logic [3:0]       count_q;

	pd_scp_pkg::tbl_ctl_t tbl_ctl;
	pd_scp_pkg::entry_t   rd_entry;

	assign accept   = cmd_valid && cmd_ready;
	assign out_free = !res_valid_q || res_ready;

	pd_scp_table #(
		.DEPTH(MAX_ENTRIES),
		.IDX_W(IDX_W)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tbl_ctl),
		.wr_idx (ld_idx[IDX_W-1:0]),
		.wr_data(ld_entry),
		.rd_idx (walk_idx_q[IDX_W-1:0]),
		.rd_data(rd_entry)
	);

	// byte load: a start mark clears everything before the byte is taken
	always_comb begin
		ld_pos  = item_q.first_byte ? '0 : pos_q;
		ld_hdr  = item_q.first_byte ? '0 : hdr_q;
		ld_cnt  = item_q.first_byte ? '0 : cnt_q;
		ld_word = item_q.first_byte ? '0 : word_q;
		ld_err  = item_q.first_byte ? 1'b0 : err_q;
		ld_off  = ld_hdr[15] ? 6'd4 : 6'd2;
		ld_rel  = ld_pos - ld_off;
		ld_idx  = ld_rel[5:2];

		ld_pos_n  = ld_pos;
		ld_hdr_n  = ld_hdr;
		ld_cnt_n  = ld_cnt;
		ld_word_n = ld_word;
		ld_err_n  = ld_err;
		ld_res_en = 1'b0;
		ld_wr_en  = 1'b0;
		ld_res    = '0;
		ld_entry  = '0;

		if (!ld_err && ({1'b0, ld_pos} < 7'(pd_scp_pkg::MAX_MSG_BYTES))) begin
			if (ld_pos != 6'd63) begin
				ld_pos_n = ld_pos + 6'd1;
			end
			if (ld_pos == 6'd0) begin
				ld_hdr_n[7:0] = item_q.msg_byte;
			end else if (ld_pos == 6'd1) begin
				ld_hdr_n[15:8] = item_q.msg_byte;
				ld_cnt_n       = item_q.msg_byte[6:4];
				if (item_q.msg_byte[6:4] == 3'd0 ||
				    5'(item_q.msg_byte[6:4]) > 5'(MAX_ENTRIES)) begin
					ld_err_n           = 1'b1;
					ld_res_en          = 1'b1;
					ld_res.result_kind = pd_scp_pkg::RK_ERROR;
				end
			end else if (ld_pos >= ld_off && 5'(ld_idx) < 5'(ld_cnt) &&
			             5'(ld_idx) < 5'(MAX_ENTRIES)) begin
				if (ld_rel[1:0] == 2'd0) begin
					ld_word_n = {24'd0, item_q.msg_byte};
				end else begin
					ld_word_n = ld_word | (32'(item_q.msg_byte) << {ld_rel[1:0], 3'd0});
				end
				if (ld_rel[1:0] == 2'd3) begin
					ld_entry           = pd_scp_pkg::decode_pdo(ld_word_n);
					ld_wr_en           = 1'b1;
					ld_res_en          = 1'b1;
					ld_res.result_kind = pd_scp_pkg::RK_ENTRY;
					ld_res.entry_index = ld_idx;
					ld_res.entry_kind  = ld_entry.kind;
					ld_res.value_a     = ld_entry.val_a;
					ld_res.value_b     = ld_entry.val_b;
					ld_res.value_c     = ld_entry.val_c;
					ld_res.last_entry  = (5'(ld_idx) + 5'd1) == 5'(ld_cnt);
				end
			end
		end
	end

	always_comb begin
		qry_res             = '0;
		qry_res.result_kind = pd_scp_pkg::RK_QUERY;
		qry_res.found       = found_q;
		qry_res.limit_mv    = limit_q;
		qry_res.fixed_count = count_q;
		qry_res.has_pps     = pps_q;
		qry_res.has_avs     = avs_q;
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			pd_scp_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_n = (cmd.opcode == pd_scp_pkg::OP_LOAD) ?
						pd_scp_pkg::ST_LOAD : pd_scp_pkg::ST_WALK;
				end
			end
			pd_scp_pkg::ST_LOAD: begin
				if (ld_go) begin
					state_n = pd_scp_pkg::ST_IDLE;
				end
			end
			pd_scp_pkg::ST_WALK: begin
				if (rd_vld_s1 && rd_last_s1) begin
					state_n = pd_scp_pkg::ST_REPLY;
				end
			end
			pd_scp_pkg::ST_REPLY: begin
				if (out_free) begin
					state_n = pd_scp_pkg::ST_IDLE;
				end
			end
			default: state_n = pd_scp_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd_ready     = 1'b0;
		ld_go         = 1'b0;
		rep_go        = 1'b0;
		walk_issue    = 1'b0;
		unique case (state_q)
			pd_scp_pkg::ST_IDLE:  cmd_ready = 1'b1;
			pd_scp_pkg::ST_LOAD:  ld_go = !ld_res_en || out_free;
			pd_scp_pkg::ST_WALK:  walk_issue = walk_idx_q < CNT_W'(MAX_ENTRIES);
			pd_scp_pkg::ST_REPLY: rep_go = out_free;
			default: ;
		endcase
		tbl_ctl.clr   = ld_go && item_q.first_byte;
		tbl_ctl.wr_en = ld_go && ld_wr_en;
		tbl_ctl.rd_en = walk_issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pd_scp_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
			pos_q       <= '0;
			hdr_q       <= '0;
			cnt_q       <= '0;
			word_q      <= '0;
			err_q       <= 1'b0;
			walk_idx_q  <= '0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			found_q     <= 1'b0;
			lim_done_q  <= 1'b0;
			pps_q       <= 1'b0;
			avs_q       <= 1'b0;
			limit_q     <= '0;
			count_q     <= '0;
		end else begin
			state_q <= state_n;

			if ((ld_go && ld_res_en) || rep_go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			if (ld_go) begin
				pos_q  <= ld_pos_n;
				hdr_q  <= ld_hdr_n;
				cnt_q  <= ld_cnt_n;
				word_q <= ld_word_n;
				err_q  <= ld_err_n;
			end

			if (accept) begin
				walk_idx_q <= '0;
				found_q    <= 1'b0;
				lim_done_q <= 1'b0;
				pps_q      <= 1'b0;
				avs_q      <= 1'b0;
				limit_q    <= '0;
				count_q    <= '0;
			end else if (walk_issue) begin
				walk_idx_q <= walk_idx_q + CNT_W'(1);
			end

			rd_vld_s1  <= walk_issue;
			rd_last_s1 <= walk_issue && (walk_idx_q == CNT_W'(MAX_ENTRIES - 1));

			if (rd_vld_s1) begin
				if (rd_entry.kind == pd_scp_pkg::KIND_FIXED) begin
					count_q <= count_q + 4'd1;
					if (rd_entry.val_a == item_q.req_mv) begin
						found_q <= 1'b1;
					end
				end else if (rd_entry.kind == pd_scp_pkg::KIND_PPS ||
				             rd_entry.kind == pd_scp_pkg::KIND_AVS) begin
					if (rd_entry.val_a <= item_q.req_mv && item_q.req_mv <= rd_entry.val_b) begin
						found_q <= 1'b1;
					end
					if (rd_entry.kind == pd_scp_pkg::KIND_PPS) begin
						pps_q <= 1'b1;
					end else begin
						avs_q <= 1'b1;
					end
					// first entry of the requested range type wins
					if (!lim_done_q && {1'b0, item_q.limit_kind} == rd_entry.kind) begin
						limit_q    <= item_q.want_max ? rd_entry.val_b : rd_entry.val_a;
						lim_done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
		if (ld_go && ld_res_en) begin
			res_q <= ld_res;
		end else if (rep_go) begin
			res_q <= qry_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/pd_scp_table.sv @@
`default_nettype none

module pd_scp_table #(
	parameter int DEPTH = pd_scp_pkg::MAX_ENTRIES_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire pd_scp_pkg::tbl_ctl_t ctl,
	input  wire [IDX_W-1:0]          wr_idx,
	input  wire pd_scp_pkg::entry_t  wr_data,
	input  wire [IDX_W-1:0]          rd_idx,
	output pd_scp_pkg::entry_t       rd_data
);

	pd_scp_pkg::entry_t mem_q [DEPTH];
	pd_scp_pkg::entry_t mem_rd_q;
	logic [DEPTH-1:0]   vld_q;
	logic               hit_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (ctl.rd_en) begin
			mem_rd_q <= mem_q[rd_idx];
		end
	end

	// one valid bit per slot; an unwritten slot reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			hit_s1 <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (ctl.rd_en) begin
				hit_s1 <= vld_q[rd_idx];
			end
		end
	end

	assign rd_data = hit_s1 ? mem_rd_q : '0;

endmodule

`default_nettype wire

@@ hw/rtl/pd_scp_checker.sv @@
`default_nettype none

module pd_scp_checker #(
	parameter int MAX_ENTRIES = pd_scp_pkg::MAX_ENTRIES_DEF
) (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   cmd_valid,
	input wire                   cmd_ready,
	input wire pd_scp_pkg::cmd_t cmd,
	input wire                   res_valid,
	input wire                   res_ready,
	input wire pd_scp_pkg::res_t res
);

	// a stalled result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// queries walk the table, so the next command is not taken straight after a query
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.opcode != pd_scp_pkg::OP_LOAD |=> !cmd_ready)
		else $error("command taken during table walk");

	a_entry_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind == pd_scp_pkg::RK_ENTRY |->
			5'(res.entry_index) < 5'(MAX_ENTRIES) && !res.found &&
			res.limit_mv == 16'd0 && res.fixed_count == 4'd0 &&
			!res.has_pps && !res.has_avs && res.entry_kind != pd_scp_pkg::KIND_EMPTY)
		else $error("bad decoded entry result");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind == pd_scp_pkg::RK_ERROR |->
			res.entry_index == 4'd0 && res.entry_kind == 3'd0 &&
			res.value_a == 16'd0 && res.value_b == 16'd0 && res.value_c == 16'd0 &&
			!res.last_entry && !res.found && res.limit_mv == 16'd0 &&
			res.fixed_count == 4'd0 && !res.has_pps && !res.has_avs)
		else $error("error result carries data");

	a_query_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind == pd_scp_pkg::RK_QUERY |->
			res.entry_kind == 3'd0 && res.value_a == 16'd0 && res.value_b == 16'd0 &&
			res.value_c == 16'd0 && !res.last_entry && res.entry_index == 4'd0)
		else $error("query answer carries entry data");

endmodule

bind pd_source_cap_parser pd_scp_checker #(
	.MAX_ENTRIES(MAX_ENTRIES)
) u_pd_scp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.cmd      (cmd),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res      (res)
);

`default_nettype wire

@@ tb/sv/pd_source_cap_parser_test.sv @@
`default_nettype none

module pd_source_cap_parser_test;

	localparam int N_SLOTS     = pd_scp_pkg::MAX_ENTRIES_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 400;

	// object types the package leaves unnamed; all decode as reserved
	localparam logic [1:0] PDO_BATTERY  = 2'd1;
	localparam logic [1:0] PDO_VARIABLE = 2'd2;
	localparam logic [1:0] APDO_RSVD_2  = 2'd2;
	localparam logic [1:0] APDO_RSVD_3  = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	pd_scp_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	pd_scp_pkg::res_t res;

	// parser state as seen from outside
	logic [5:0]  byte_pos = '0;
	logic [15:0] hdr_word = '0;
	logic [2:0]  obj_count = '0;
	logic [31:0] pdo_word = '0;
	logic        hdr_error = 1'b0;
	pd_scp_pkg::entry_t pdo_table [N_SLOTS];

	pd_scp_pkg::res_t pdo_reports_due[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int cmds_sent = 0;
	int mismatches = 0;
	int n_entries = 0;
	int n_count_errors = 0;
	int n_answers = 0;
	int quiet_cycles = 0;

	pd_source_cap_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always #10 clk = ~clk;

	initial begin
		for (int i = 0; i < N_SLOTS; i++) begin
			pdo_table[i] = '0;
		end
	end

	function automatic pd_scp_pkg::entry_t decode_word(input logic [31:0] w);
		pd_scp_pkg::entry_t e;
		e = '0;
		e.kind = pd_scp_pkg::KIND_RSVD;
		if (w[31:30] == pd_scp_pkg::PDO_FIXED) begin
			e.kind  = pd_scp_pkg::KIND_FIXED;
			e.val_a = 16'(int'(w[19:10]) * 50);
			e.val_b = 16'(int'(w[9:0]) * 10);
		end else if (w[31:30] == pd_scp_pkg::PDO_APDO &&
		             w[29:28] == pd_scp_pkg::APDO_PPS) begin
			e.kind  = pd_scp_pkg::KIND_PPS;
			e.val_a = 16'(int'(w[15:8]) * 100);
			e.val_b = 16'(int'(w[24:17]) * 100);
			e.val_c = 16'(int'(w[6:0]) * 50);
		end else if (w[31:30] == pd_scp_pkg::PDO_APDO &&
		             w[29:28] == pd_scp_pkg::APDO_AVS) begin
			e.kind  = pd_scp_pkg::KIND_AVS;
			e.val_a = 16'(int'(w[15:8]) * 100);
			e.val_b = 16'(int'(w[25:17]) * 100);
			e.val_c = 16'(w[7:0]);
		end
		return e;
	endfunction

	// update the table for an accepted load byte, or walk it for a query, and queue what the command should report
	task automatic parse_source_caps(input pd_scp_pkg::cmd_t c);
		pd_scp_pkg::res_t r;
		pd_scp_pkg::entry_t e;
		logic [5:0] pos;
		logic [5:0] rel;
		logic [5:0] offset;
		logic [3:0] slot;
		int fixed_n;
		bit lim_done;
		r = '0;
		if (c.opcode == pd_scp_pkg::OP_LOAD) begin
			if (c.first_byte) begin
				for (int i = 0; i < N_SLOTS; i++) begin
					pdo_table[i] = '0;
				end
				byte_pos = '0;
				hdr_word = '0;
				obj_count = '0;
				pdo_word = '0;
				hdr_error = 1'b0;
			end
			pos = byte_pos;
			if (hdr_error || pos >= pd_scp_pkg::MAX_MSG_BYTES)
				return;
			if (byte_pos < 6'd63)
				byte_pos++;
			if (pos == 6'd0) begin
				hdr_word[7:0] = c.msg_byte;
				return;
			end
			if (pos == 6'd1) begin
				hdr_word[15:8] = c.msg_byte;
				obj_count = hdr_word[14:12];
				if (obj_count == 3'd0 || int'(obj_count) > N_SLOTS) begin
					hdr_error = 1'b1;
					r.result_kind = pd_scp_pkg::RK_ERROR;
					pdo_reports_due.push_back(r);
				end
				return;
			end
			offset = hdr_word[15] ? 6'd4 : 6'd2;
			if (pos < offset)
				return;
			rel = pos - offset;
			slot = 4'(rel >> 2);
			if (slot >= 4'(obj_count) || int'(slot) >= N_SLOTS)
				return;
			if (rel[1:0] == 2'd0)
				pdo_word = '0;
			pdo_word |= 32'(c.msg_byte) << (8 * rel[1:0]);
			if (rel[1:0] == 2'd3) begin
				e = decode_word(pdo_word);
				pdo_table[slot] = e;
				r.result_kind = pd_scp_pkg::RK_ENTRY;
				r.entry_index = slot;
				r.entry_kind  = e.kind;
				r.value_a     = e.val_a;
				r.value_b     = e.val_b;
				r.value_c     = e.val_c;
				r.last_entry  = (int'(slot) + 1 == int'(obj_count));
				pdo_reports_due.push_back(r);
			end
		end else begin
			fixed_n = 0;
			lim_done = 1'b0;
			for (int i = 0; i < N_SLOTS; i++) begin
				e = pdo_table[i];
				if (e.kind == pd_scp_pkg::KIND_FIXED) begin
					fixed_n++;
					if (e.val_a == c.req_mv)
						r.found = 1'b1;
				end else if (e.kind == pd_scp_pkg::KIND_PPS ||
				             e.kind == pd_scp_pkg::KIND_AVS) begin
					if (e.val_a <= c.req_mv && c.req_mv <= e.val_b)
						r.found = 1'b1;
					if (e.kind == pd_scp_pkg::KIND_PPS)
						r.has_pps = 1'b1;
					else
						r.has_avs = 1'b1;
					if (!lim_done && 3'(c.limit_kind) == e.kind) begin
						r.limit_mv = c.want_max ? e.val_b : e.val_a;
						lim_done = 1'b1;
					end
				end
			end
			r.result_kind = pd_scp_pkg::RK_QUERY;
			r.fixed_count = 4'(fixed_n);
			pdo_reports_due.push_back(r);
		end
	endtask

	function automatic int pick_gap();
		if (send_idle_pct == 0 || $urandom_range(0, 99) >= send_idle_pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	task automatic send_cmd(input pd_scp_pkg::cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		parse_source_caps(c);
		cmds_sent++;
	endtask

	task automatic send_load(input logic [7:0] b, input bit first);
		pd_scp_pkg::cmd_t c;
		c = pd_scp_pkg::cmd_t'($urandom);
		c.opcode = pd_scp_pkg::OP_LOAD;
		c.msg_byte = b;
		c.first_byte = first;
		send_cmd(c);
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++) begin
			send_load(w[8 * k +: 8], 1'b0);
		end
	endtask

	task automatic send_query(input logic [1:0] op, input logic [15:0] mv,
			input logic [1:0] lk, input bit wm);
		pd_scp_pkg::cmd_t c;
		c = pd_scp_pkg::cmd_t'($urandom);
		c.opcode = op;
		c.req_mv = mv;
		c.limit_kind = lk;
		c.want_max = wm;
		send_cmd(c);
	endtask

	function automatic logic [1:0] pick_query_op();
		return 2'($urandom_range(pd_scp_pkg::OP_CHECK, pd_scp_pkg::OP_COUNT));
	endfunction

	// often voltages that sit on or next to a table edge, else extremes or random values
	function automatic logic [15:0] pick_req_mv();
		pd_scp_pkg::entry_t e;
		logic [15:0] v;
		case ($urandom_range(0, 5))
			0, 1: begin
				e = pdo_table[$urandom_range(0, N_SLOTS - 1)];
				v = $urandom_range(0, 1) ? e.val_a : e.val_b;
				v = v + 16'($urandom_range(0, 2)) - 16'd1;
			end
			2: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [31:0] random_pdo();
		logic [31:0] w;
		int r;
		w = $urandom;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			w[31:30] = pd_scp_pkg::PDO_FIXED;
		end else if (r < 60) begin
			w[31:28] = {pd_scp_pkg::PDO_APDO, pd_scp_pkg::APDO_PPS};
		end else if (r < 80) begin
			w[31:28] = {pd_scp_pkg::PDO_APDO, pd_scp_pkg::APDO_AVS};
		end else begin
			case ($urandom_range(0, 3))
				0: w[31:30] = PDO_BATTERY;
				1: w[31:30] = PDO_VARIABLE;
				2: w[31:28] = {pd_scp_pkg::PDO_APDO, APDO_RSVD_2};
				default: w[31:28] = {pd_scp_pkg::PDO_APDO, APDO_RSVD_3};
			endcase
		end
		return w;
	endfunction

	// keep < 0 sends the whole message
	task automatic send_message(input int n_obj, input bit ext, input bit mark,
			input int keep, input int surplus);
		logic [7:0] msg[$];
		logic [15:0] hdr;
		logic [31:0] w;
		hdr = 16'($urandom);
		hdr[14:12] = 3'(n_obj);
		hdr[15] = ext;
		msg.push_back(hdr[7:0]);
		msg.push_back(hdr[15:8]);
		if (ext) begin
			msg.push_back(8'($urandom));
			msg.push_back(8'($urandom));
		end
		for (int k = 0; k < n_obj; k++) begin
			w = random_pdo();
			for (int j = 0; j < 4; j++) begin
				msg.push_back(w[8 * j +: 8]);
			end
		end
		repeat (surplus) msg.push_back(8'($urandom));
		if (keep >= 0) begin
			while (msg.size() > keep) void'(msg.pop_back());
		end
		foreach (msg[i]) begin
			send_load(msg[i], mark && i == 0);
		end
	endtask

	task automatic test_directed_decode();
		// header straight out of reset with no start mark: three objects
		send_load(8'h00, 1'b0);
		send_load(8'h30, 1'b0);
		send_word(32'h000F_FFFF);  // fixed, max voltage and current
		send_word(32'hC1FE_FF7F);  // PPS, all fields at max
		send_word(32'hD3FE_32FF);  // AVS 5 V to max, max power
		send_load(8'hAA, 1'b0);    // past the last object
		send_query(pd_scp_pkg::OP_CHECK, 16'd51150, 2'(pd_scp_pkg::KIND_EMPTY), 1'b0);
		send_query(pd_scp_pkg::OP_CHECK, 16'd25500, 2'(pd_scp_pkg::KIND_EMPTY), 1'b0);
		send_query(pd_scp_pkg::OP_CHECK, 16'd4999, 2'(pd_scp_pkg::KIND_EMPTY), 1'b0);
		send_query(pd_scp_pkg::OP_LIMIT, 16'd0, 2'(pd_scp_pkg::KIND_PPS), 1'b1);
		send_query(pd_scp_pkg::OP_LIMIT, 16'd0, 2'(pd_scp_pkg::KIND_AVS), 1'b0);
		send_query(pd_scp_pkg::OP_LIMIT, 16'd0, 2'(pd_scp_pkg::KIND_EMPTY), 1'b1);
		send_query(pd_scp_pkg::OP_LIMIT, 16'd0, 2'(pd_scp_pkg::KIND_FIXED), 1'b0);
		send_query(pd_scp_pkg::OP_COUNT, 16'hFFFF, 2'(pd_scp_pkg::KIND_AVS), 1'b1);
	endtask

	task automatic test_directed_count_error();
		// extended header with zero objects; the table must come back empty
		send_load(8'h00, 1'b1);
		send_load(8'h80, 1'b0);
		send_load(8'h55, 1'b0);
		send_query(pd_scp_pkg::OP_COUNT, 16'd0, 2'(pd_scp_pkg::KIND_PPS), 1'b0);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		send_message(7, 1'b0, 1'b1, -1, 0);
		repeat (12) send_query(pick_query_op(), pick_req_mv(), 2'($urandom), 1'($urandom));
	endtask

	task automatic test_random_traffic(input int n_items, input int idle_pct,
			input int stall_pct);
		int start;
		int r;
		int n;
		start = cmds_sent;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (cmds_sent - start < n_items) begin
			r = $urandom_range(0, 99);
			n = $urandom_range(1, 7);
			if (r < 75) begin
				send_message(n, $urandom_range(0, 9) < 3, 1'b1, -1,
					$urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
			end else if (r < 82) begin
				send_message(0, 1'($urandom), 1'b1, -1, $urandom_range(0, 4));
			end else if (r < 88) begin
				send_message(n, 1'($urandom), 1'b1, $urandom_range(1, 2 + 4 * n), 0);
			end else if (r < 94) begin
				// long tail can run the position past the byte limit
				send_message(n, 1'($urandom), 1'b1, -1, $urandom_range(16, 40));
			end else begin
				repeat ($urandom_range(1, 6)) send_load(8'($urandom), 1'b0);
			end
			repeat ($urandom_range(1, 4)) send_query(pick_query_op(),
				pick_req_mv(), 2'($urandom), 1'($urandom));
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				res_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else if (recv_stall_pct != 0 && $urandom_range(0, 299) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else begin
				res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		pd_scp_pkg::res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready) begin
				if (pdo_reports_due.size() == 0) begin
					$error("result transfer with nothing outstanding, kind %0d",
						res.result_kind);
					mismatches++;
				end else begin
					want = pdo_reports_due.pop_front();
					check_field("result_kind", 16'(want.result_kind), 16'(res.result_kind));
					check_field("entry_index", 16'(want.entry_index), 16'(res.entry_index));
					check_field("entry_kind", 16'(want.entry_kind), 16'(res.entry_kind));
					check_field("value_a", want.value_a, res.value_a);
					check_field("value_b", want.value_b, res.value_b);
					check_field("value_c", want.value_c, res.value_c);
					check_field("last_entry", 16'(want.last_entry), 16'(res.last_entry));
					check_field("found", 16'(want.found), 16'(res.found));
					check_field("limit_mv", want.limit_mv, res.limit_mv);
					check_field("fixed_count", 16'(want.fixed_count), 16'(res.fixed_count));
					check_field("has_pps", 16'(want.has_pps), 16'(res.has_pps));
					check_field("has_avs", 16'(want.has_avs), 16'(res.has_avs));
					case (want.result_kind)
						pd_scp_pkg::RK_ENTRY: n_entries++;
						pd_scp_pkg::RK_ERROR: n_count_errors++;
						default: n_answers++;
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("pd_source_cap_parser_test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_decode();
		test_directed_count_error();
		test_backpressure();
		test_random_traffic(450, 0, 0);
		test_random_traffic(450, 25, 30);
		test_random_traffic(450, 60, 55);
		cmd_valid <= 1'b0;
		while (pdo_reports_due.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("%0d commands sent: %0d decoded objects, %0d count errors, %0d answers",
			cmds_sent, n_entries, n_count_errors, n_answers);
		$display("covered extended headers, reserved objects, truncated and overlong "
			, "messages, and idle and stall on both sides");
		if (mismatches == 0)
			$display("pd_source_cap_parser_test passed");
		else
			$display("pd_source_cap_parser_test failed");
		$finish;
	end

endmodule

`default_nettype wire
